// ===== rtl/lphi_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lphi_pkg
// Shared types, constants and helpers of the linear-probe id hash index.
// ============================================================================
package lphi_pkg;

	// Table geometry
	localparam int MAX_SLOTS_LOG2 = 10;
	localparam int MIN_SLOTS_LOG2 = 4;
	localparam int SLOT_DEPTH     = 1 << MAX_SLOTS_LOG2;
	localparam int IDX_W          = MAX_SLOTS_LOG2;
	localparam int SLOT_W         = MAX_SLOTS_LOG2 + 1;
	localparam int LG_W           = $clog2(MAX_SLOTS_LOG2 + 1);
	localparam int CFG_W          = 4;

	// Multiplicative hash
	localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
	localparam int          HASH_SHIFT = 29;
	localparam int          HASH_TOP   = HASH_SHIFT + MAX_SLOTS_LOG2;
	localparam int          HASH_HI_W  = HASH_TOP - 32;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SLOT_W-1:0] slot_cnt_t;
	typedef logic [LG_W-1:0]   lg_t;

	// Operation codes
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LOOKUP = 2'd0;
	localparam mode_t MODE_INSERT = 2'd1;
	localparam mode_t MODE_CLEAR  = 2'd2;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_FOUND     = 3'd0;
	localparam status_t ST_UPDATED   = 3'd1;
	localparam status_t ST_INSERTED  = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

	// One table slot as held in memory
	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_SWEEP,
		S_DONE
	} state_t;

	// Clamp the size register into the supported range
	function automatic lg_t clamp_lg(input logic [CFG_W-1:0] v);
		lg_t r;
		if (int'(v) < MIN_SLOTS_LOG2)
			r = lg_t'(MIN_SLOTS_LOG2);
		else if (int'(v) > MAX_SLOTS_LOG2)
			r = lg_t'(MAX_SLOTS_LOG2);
		else
			r = lg_t'(v);
		return r;
	endfunction

endpackage

// ===== rtl/lphi_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lphi_if
// Valid/ready channels of the hash index: request, result, size register.
// ============================================================================
interface lphi_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] key;
	logic [31:0]        value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lphi_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] found_value;

	modport source (output valid, output status, output found_value, input ready);
	modport sink   (input valid, input status, input found_value, output ready);
endinterface

interface lphi_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] slots_log2;

	modport source (output valid, output slots_log2, input ready);
	modport sink   (input valid, input slots_log2, output ready);
endinterface

// ===== rtl/lphi_hash.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lphi_hash
// Home slot of a key: bits from HASH_SHIFT up of key * HASH_MULT, masked.
// ============================================================================
module lphi_hash (
	input  logic [31:0]    key,
	input  lphi_pkg::idx_t mask,
	output lphi_pkg::idx_t home
);

	logic [63:0]                     prod_lo;
	logic [lphi_pkg::HASH_HI_W-1:0]  prod_hi;
	logic [lphi_pkg::HASH_TOP-1:0]   prod_sum;

	// Only the low HASH_TOP bits of the 64-bit product matter: one 32x32
	// product plus a narrow correction for the multiplier bits above 31
	assign prod_lo  = 64'(key) * 64'(lphi_pkg::HASH_MULT[31:0]);
	assign prod_hi  = lphi_pkg::HASH_HI_W'(
		key[lphi_pkg::HASH_HI_W-1:0] *
		lphi_pkg::HASH_MULT[lphi_pkg::HASH_TOP-1:32]);
	assign prod_sum = prod_lo[lphi_pkg::HASH_TOP-1:0] + {prod_hi, 32'd0};

	assign home = prod_sum[lphi_pkg::HASH_TOP-1:lphi_pkg::HASH_SHIFT] & mask;

endmodule

// ===== rtl/linear_probe_id_hash_index.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_id_hash_index
// Open-addressing id-to-index map with linear probing in one slot memory.
// ============================================================================
// Every slot (valid, key, value) lives in one single-port synchronous memory,
// so a probe run visits one slot per cycle. A lookup or insert registers its
// result once its probe run ends. A clear sweeps the table, writing one slot
// per cycle, and the unused mode reads no slot. After reset, and after every
// write of slots_log2 (which also empties the table), the same sweep runs
// with no item accepted. The size register itself is always ready. One item
// is in work at a time. A finished result waits in the output register while
// the next item is accepted. That item's result then waits until the output
// register frees.
module linear_probe_id_hash_index (
	input  logic                 clk,
	input  logic                 arst_n,
	lphi_cfg_if.sink             cfg,
	lphi_item_if.sink            req,
	lphi_result_if.source        rsp
);

	// Slot memory
	lphi_pkg::entry_t mem [lphi_pkg::SLOT_DEPTH];
	lphi_pkg::entry_t mem_rdata;
	lphi_pkg::entry_t mem_wdata;
	lphi_pkg::idx_t   mem_addr;
	logic             mem_re;
	logic             mem_we;

	// Control and item registers
	lphi_pkg::state_t    state_q, state_d;
	lphi_pkg::lg_t       lg_q, lg_d;
	lphi_pkg::slot_cnt_t count_q, count_d;
	lphi_pkg::idx_t      idx_q, idx_d;
	lphi_pkg::idx_t      cnt_q, cnt_d;
	logic                clr_item_q, clr_item_d;
	lphi_pkg::mode_t     mode_q;
	logic [31:0]         key_q;
	logic [31:0]         value_q;
	lphi_pkg::status_t   res_status_q, res_status_d;
	logic [31:0]         res_found_q, res_found_d;
	logic                rsp_valid_q, rsp_valid_d;
	lphi_pkg::status_t   rsp_status_q;
	logic [31:0]         rsp_found_q;

	// Derived values
	lphi_pkg::slot_cnt_t       slots;
	lphi_pkg::idx_t            mask;
	lphi_pkg::idx_t            next_idx;
	lphi_pkg::idx_t            home;
	logic [lphi_pkg::SLOT_W+1:0] need;
	logic [lphi_pkg::SLOT_W+1:0] limit;
	logic                      load_full;
	logic                      hit;
	logic                      empty;
	logic                      last;
	logic                      req_acc;
	logic                      cfg_acc;
	logic                      out_free;

	assign slots     = lphi_pkg::slot_cnt_t'(1) << lg_q;
	assign mask      = lphi_pkg::idx_t'(slots - lphi_pkg::slot_cnt_t'(1));
	assign next_idx  = (idx_q + lphi_pkg::idx_t'(1)) & mask;
	assign need      = {count_q + lphi_pkg::slot_cnt_t'(1), 2'b00};
	assign limit     = {1'b0, slots, 1'b0} + {2'b00, slots};
	assign load_full = need >= limit;
	assign hit       = mem_rdata.valid && (mem_rdata.key == key_q);
	assign empty     = !mem_rdata.valid;
	assign last      = cnt_q == mask;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign cfg.ready       = 1'b1;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_value = rsp_found_q;

	lphi_hash u_hash (
		.key  (req.key),
		.mask (mask),
		.home (home)
	);

	// Next state, memory access and result selection
	always_comb begin
		state_d      = state_q;
		lg_d         = lg_q;
		count_d      = count_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		clr_item_d   = clr_item_q;
		res_status_d = res_status_q;
		res_found_d  = res_found_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = idx_q;
		mem_wdata    = '0;
		req.ready    = 1'b0;

		case (state_q)
			lphi_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req_acc) begin
					idx_d        = home;
					cnt_d        = '0;
					res_status_d = lphi_pkg::ST_NOT_FOUND;
					res_found_d  = '0;
					case (req.mode)
						lphi_pkg::MODE_LOOKUP, lphi_pkg::MODE_INSERT: begin
							state_d = lphi_pkg::S_READ;
						end
						lphi_pkg::MODE_CLEAR: begin
							idx_d      = '0;
							count_d    = '0;
							clr_item_d = 1'b1;
							state_d    = lphi_pkg::S_SWEEP;
						end
						default: begin
							state_d = lphi_pkg::S_DONE;
						end
					endcase
				end
			end

			lphi_pkg::S_READ: begin
				mem_re  = 1'b1;
				state_d = lphi_pkg::S_CHECK;
			end

			// One slot checked per cycle; the next read goes out alongside
			lphi_pkg::S_CHECK: begin
				if (hit) begin
					state_d = lphi_pkg::S_DONE;
					if (mode_q == lphi_pkg::MODE_INSERT) begin
						mem_we       = 1'b1;
						mem_wdata    = '{valid: 1'b1, key: key_q, value: value_q};
						res_status_d = lphi_pkg::ST_UPDATED;
					end else begin
						res_status_d = lphi_pkg::ST_FOUND;
						res_found_d  = mem_rdata.value;
					end
				end else if (empty) begin
					state_d = lphi_pkg::S_DONE;
					if (mode_q == lphi_pkg::MODE_INSERT) begin
						if (load_full) begin
							res_status_d = lphi_pkg::ST_FULL;
						end else begin
							mem_we       = 1'b1;
							mem_wdata    = '{valid: 1'b1, key: key_q, value: value_q};
							count_d      = count_q + lphi_pkg::slot_cnt_t'(1);
							res_status_d = lphi_pkg::ST_INSERTED;
						end
					end else begin
						res_status_d = lphi_pkg::ST_NOT_FOUND;
					end
				end else if (last) begin
					// whole run occupied by other keys
					state_d      = lphi_pkg::S_DONE;
					res_status_d = (mode_q == lphi_pkg::MODE_INSERT) ?
						lphi_pkg::ST_FULL : lphi_pkg::ST_NOT_FOUND;
				end else begin
					mem_re   = 1'b1;
					mem_addr = next_idx;
					idx_d    = next_idx;
					cnt_d    = cnt_q + lphi_pkg::idx_t'(1);
				end
			end

			// Empty the slots in use, one per cycle
			lphi_pkg::S_SWEEP: begin
				mem_we = 1'b1;
				idx_d  = next_idx;
				if (idx_q == mask) begin
					if (clr_item_q) begin
						res_status_d = lphi_pkg::ST_FOUND;
						res_found_d  = '0;
						state_d      = lphi_pkg::S_DONE;
					end else begin
						state_d = lphi_pkg::S_IDLE;
					end
				end
			end

			lphi_pkg::S_DONE: begin
				if (out_free) begin
					rsp_valid_d = 1'b1;
					state_d     = lphi_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = lphi_pkg::S_IDLE;
			end
		endcase

		// Size change empties the table: restart the sweep at the new size
		if (cfg_acc) begin
			lg_d       = lphi_pkg::clamp_lg(cfg.slots_log2);
			count_d    = '0;
			idx_d      = '0;
			clr_item_d = 1'b0;
			state_d    = lphi_pkg::S_SWEEP;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphi_pkg::S_SWEEP;
			lg_q        <= lphi_pkg::lg_t'(lphi_pkg::MIN_SLOTS_LOG2);
			count_q     <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			clr_item_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			lg_q        <= lg_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			clr_item_q  <= clr_item_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q  <= req.mode;
			key_q   <= $unsigned(req.key);
			value_q <= req.value;
		end
		res_status_q <= res_status_d;
		res_found_q  <= res_found_d;
		if (state_q == lphi_pkg::S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_found_q  <= res_found_q;
		end
	end

	// Slot memory, one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			mem_rdata <= mem[mem_addr];
	end

endmodule

// ===== bench/linear_probe_id_hash_index_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_id_hash_index_tb
// Self-checking bench for the linear-probe id hash index.
// ============================================================================
// A shadow copy of the table is updated as each request item is accepted.
// It yields the answer the block owes, and every returned item is compared
// field by field against the oldest owed answer. The run opens with directed
// items at the reset size: empty-table misses, extreme ids, an all-ones index,
// an update, the unused mode, filling to the load limit, and clear. Random
// phases follow, each under a different size register value. Out-of-range
// values are included. Both handshakes idle at random, and the result side
// sometimes holds off for a long stretch so the block backs up.
// ============================================================================
module linear_probe_id_hash_index_tb;

	localparam lphi_pkg::mode_t MODE_UNUSED = 2'd3;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned KEY_POOL    = 48;

	typedef struct packed {
		lphi_pkg::mode_t    mode;
		logic signed [31:0] key;
		logic [31:0]        value;
	} table_op_t;

	typedef struct packed {
		lphi_pkg::status_t status;
		logic [31:0]       found_value;
		lphi_pkg::mode_t   mode;
		logic [31:0]       key;
	} table_answer_t;

	logic clk = 1'b0;
	logic arst_n;

	lphi_cfg_if    cfg_ch();
	lphi_item_if   req_ch();
	lphi_result_if rsp_ch();

	linear_probe_id_hash_index dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow table
	bit              shadow_live  [lphi_pkg::SLOT_DEPTH];
	logic [31:0]     shadow_key   [lphi_pkg::SLOT_DEPTH];
	logic [31:0]     shadow_index [lphi_pkg::SLOT_DEPTH];
	int unsigned     shadow_entries;
	logic [lphi_pkg::CFG_W-1:0] shadow_size_reg;

	table_op_t       queued_ops[$];
	table_answer_t   owed_answers[$];
	logic [31:0]     recent_keys[$];

	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned miss_count;
	int unsigned ops_sent;
	int unsigned answers_checked;
	int unsigned size_writes;
	int unsigned clears_done;
	int unsigned status_tally [5];

	function automatic void wipe_shadow();
		foreach (shadow_live[i])
			shadow_live[i] = 1'b0;
		shadow_entries = 0;
	endfunction

	// Apply one op to the shadow table and return the answer it owes
	function automatic table_answer_t apply_to_shadow(table_op_t op);
		table_answer_t ans;
		logic [31:0]   ukey;
		logic [63:0]   prod;
		int unsigned   lg, span, mask, slot, spot;
		bit            hit, open;
		ukey = op.key;
		ans.mode = op.mode;
		ans.key = ukey;
		ans.status = lphi_pkg::ST_NOT_FOUND;
		ans.found_value = '0;
		lg = shadow_size_reg;
		if (lg < lphi_pkg::MIN_SLOTS_LOG2)
			lg = lphi_pkg::MIN_SLOTS_LOG2;
		if (lg > lphi_pkg::MAX_SLOTS_LOG2)
			lg = lphi_pkg::MAX_SLOTS_LOG2;
		span = 1 << lg;
		mask = span - 1;
		prod = {32'd0, ukey} * lphi_pkg::HASH_MULT;
		slot = 32'((prod >> lphi_pkg::HASH_SHIFT) & 64'(mask));
		// walk the probe run from the home slot, wrapping at the used size
		hit = 1'b0;
		open = 1'b0;
		spot = 0;
		for (int n = 0; n < span; n++) begin
			if (!shadow_live[slot]) begin
				open = 1'b1;
				spot = slot;
				break;
			end
			if (shadow_key[slot] == ukey) begin
				hit = 1'b1;
				spot = slot;
				break;
			end
			slot = (slot + 1) & mask;
		end
		case (op.mode)
			lphi_pkg::MODE_LOOKUP: begin
				if (hit) begin
					ans.status = lphi_pkg::ST_FOUND;
					ans.found_value = shadow_index[spot];
				end
			end
			lphi_pkg::MODE_INSERT: begin
				if (hit) begin
					shadow_index[spot] = op.value;
					ans.status = lphi_pkg::ST_UPDATED;
				end else if (!open || (shadow_entries + 1) * 4 >= span * 3) begin
					ans.status = lphi_pkg::ST_FULL;
				end else begin
					shadow_live[spot] = 1'b1;
					shadow_key[spot] = ukey;
					shadow_index[spot] = op.value;
					shadow_entries++;
					ans.status = lphi_pkg::ST_INSERTED;
				end
			end
			lphi_pkg::MODE_CLEAR: begin
				wipe_shadow();
				ans.status = lphi_pkg::ST_FOUND;
				clears_done++;
			end
			default: ;
		endcase
		status_tally[ans.status]++;
		return ans;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap(int unsigned pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 19))
			0: return '1;
			1: return '0;
			2: return 32'hFFFF_FFFE;
			default: return $urandom();
		endcase
	endfunction

	// Random op: keys mostly reused so lookups hit and inserts update
	function automatic table_op_t random_op(int unsigned clear_odds);
		table_op_t   op;
		int unsigned roll;
		roll = $urandom_range(0, 999);
		if (recent_keys.size() > 0 && $urandom_range(0, 99) < 60)
			op.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		else
			op.key = $urandom();
		op.value = pick_value();
		if (roll < clear_odds)
			op.mode = lphi_pkg::MODE_CLEAR;
		else if (roll < 450)
			op.mode = lphi_pkg::MODE_INSERT;
		else if (roll < 940)
			op.mode = lphi_pkg::MODE_LOOKUP;
		else if (roll < 970)
			op.mode = MODE_UNUSED;
		else begin
			op.mode = lphi_pkg::MODE_INSERT;
			op.key = $urandom();
		end
		if (op.mode == lphi_pkg::MODE_INSERT) begin
			recent_keys.insert(recent_keys.size(), op.key);
			if (recent_keys.size() > KEY_POOL)
				void'(recent_keys.pop_front());
		end
		return op;
	endfunction

	task automatic report_miss(string what);
		miss_count++;
		$display("ERROR @%0t: %s", $time, what);
	endtask

	task automatic queue_op(lphi_pkg::mode_t mode, logic [31:0] key, logic [31:0] value);
		table_op_t op;
		op.mode = mode;
		op.key = key;
		op.value = value;
		queued_ops.insert(queued_ops.size(), op);
	endtask

	// Block until every queued op is sent and answered
	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_ops.size() != 0 || req_ch.valid || owed_answers.size() != 0);
	endtask

	task automatic write_size(logic [lphi_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.slots_log2 <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		// a size write also empties the table
		shadow_size_reg = v;
		wipe_shadow();
		size_writes++;
	endtask

	task automatic run_phase(logic [lphi_pkg::CFG_W-1:0] size_val, int unsigned n_ops,
			int unsigned send_pct, int unsigned recv_pct, int unsigned clear_odds);
		write_size(size_val);
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		repeat (n_ops)
			queued_ops.insert(queued_ops.size(), random_op(clear_odds));
		wait_drained();
	endtask

	// Request driver
	always @(posedge clk) begin : drive_requests
		int unsigned send_gap;
		logic        next_valid;
		table_op_t   op;
		if (arst_n) begin
			next_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				op = '{mode: req_ch.mode, key: req_ch.key, value: req_ch.value};
				owed_answers.insert(owed_answers.size(), apply_to_shadow(op));
				ops_sent++;
				next_valid = 1'b0;
				send_gap = pick_gap(sender_idle_pct);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (queued_ops.size() > 0) begin
					op = queued_ops.pop_front();
					req_ch.mode <= op.mode;
					req_ch.key <= op.key;
					req_ch.value <= op.value;
					next_valid = 1'b1;
				end
			end
			req_ch.valid <= next_valid;
		end
	end

	// Result ready: random stalls plus a periodic long hold-off
	always @(posedge clk) begin : drive_result_ready
		int unsigned drained;
		int unsigned stall_left;
		int unsigned hold_left;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				drained++;
				stall_left = pick_gap(receiver_idle_pct);
				if (drained % 400 == 200)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin : check_results
		table_answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			answers_checked++;
			if (owed_answers.size() == 0) begin
				report_miss($sformatf("result with no request outstanding: status %0d value %h",
					rsp_ch.status, rsp_ch.found_value));
			end else begin
				want = owed_answers.pop_front();
				if (rsp_ch.status !== want.status)
					report_miss($sformatf("mode %0d key %h: status %0d, want %0d",
						want.mode, want.key, rsp_ch.status, want.status));
				if (rsp_ch.found_value !== want.found_value)
					report_miss($sformatf("mode %0d key %h: found_value %h, want %h",
						want.mode, want.key, rsp_ch.found_value, want.found_value));
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin : watchdog
		int unsigned quiet;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("ERROR @%0t: no handshake for %0d cycles", $time, quiet);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = lphi_pkg::MODE_LOOKUP;
		req_ch.key = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.slots_log2 = lphi_pkg::CFG_W'(lphi_pkg::MIN_SLOTS_LOG2);
		shadow_size_reg = lphi_pkg::CFG_W'(lphi_pkg::MIN_SLOTS_LOG2);
		wipe_shadow();
		sender_idle_pct = 30;
		receiver_idle_pct = 30;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed ops at the reset size of 16 slots
		queue_op(lphi_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0);
		queue_op(lphi_pkg::MODE_INSERT, 32'h8000_0000, 32'h0);
		queue_op(lphi_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
		queue_op(lphi_pkg::MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFE);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
		queue_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_op(lphi_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h1);
		// fill to eleven entries, the most 16 slots may hold
		for (int k = 1; k <= 8; k++)
			queue_op(lphi_pkg::MODE_INSERT, 32'(k), 32'(k * 3));
		queue_op(lphi_pkg::MODE_INSERT, 32'd9, 32'h5);
		queue_op(lphi_pkg::MODE_INSERT, 32'd5, 32'hA5A5_5A5A);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'd9, 32'h0);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'd5, 32'h0);
		queue_op(lphi_pkg::MODE_CLEAR, 32'd0, 32'h0);
		queue_op(lphi_pkg::MODE_LOOKUP, 32'd5, 32'h0);
		repeat (200)
			queued_ops.insert(queued_ops.size(), random_op(20));
		wait_drained();

		// random phases, one size register value each
		run_phase(4'd0, 250, 30, 30, 20);
		run_phase(4'd15, 220, 40, 20, 5);
		run_phase(4'd5, 250, 25, 40, 15);
		run_phase(4'd3, 200, 0, 0, 20);
		run_phase(4'd7, 200, 30, 30, 10);
		run_phase(4'd10, 200, 20, 50, 5);
		run_phase(4'd11, 100, 50, 10, 5);
		run_phase(4'd4, 130, 30, 30, 20);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d ops over %0d size writes: %0d hits, %0d misses, %0d new keys,",
			ops_sent, size_writes, status_tally[lphi_pkg::ST_FOUND] - clears_done,
			status_tally[lphi_pkg::ST_NOT_FOUND], status_tally[lphi_pkg::ST_INSERTED]);
		$display("%0d updates, %0d refused as full, %0d clears; %0d results checked, %0d errors",
			status_tally[lphi_pkg::ST_UPDATED], status_tally[lphi_pkg::ST_FULL], clears_done,
			answers_checked, miss_count);
		if (miss_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
